FILE: sv/lrps_pkg.sv
// Shared types, constants and helpers for the latching relay pulse sequencer.
`default_nettype none

package lrps_pkg;

  localparam int unsigned LINE_W  = 12;
  localparam int unsigned GROUP_W = 6;
  localparam int unsigned CMD_W   = 16;
  localparam int unsigned TICK_W  = 8;

  localparam logic [LINE_W-1:0]  IDLE_LINES    = 12'h555;
  localparam logic [CMD_W-1:0]   CMD_RESET     = 16'h5A5A;
  localparam logic [TICK_W-1:0]  PULSE_LEN_RST = 8'd5;
  localparam logic [TICK_W-1:0]  TICK_MAX      = 8'hFF;

  // Sequence step; codes 6 and 7 are unused
  typedef enum logic [2:0] {
    STEP_IDLE       = 3'd0,
    STEP_START      = 3'd1,
    STEP_WAIT_A_SET = 3'd2,
    STEP_WAIT_B_SET = 3'd3,
    STEP_WAIT_A_RST = 3'd4,
    STEP_WAIT_B_RST = 3'd5
  } seq_step_t;

  // Coil drive lines PS1, PR1, PS2, PR2
  typedef struct packed {
    logic b_rst;
    logic b_set;
    logic a_rst;
    logic a_set;
  } coil_t;

  localparam coil_t COIL_IDLE = '{b_rst: 1'b1, b_set: 1'b0, a_rst: 1'b1, a_set: 1'b0};

  // One result transaction
  typedef struct packed {
    logic [LINE_W-1:0] relay_lines;
    coil_t             coil;
    logic              busy;
  } lrps_result_t;

  // Mark both lines of every relay pair whose group bit equals want_set
  function automatic logic [LINE_W-1:0] pair_mask(input logic [GROUP_W-1:0] bits,
                                                   input logic want_set);
    logic [LINE_W-1:0] m;
    int                k;
    m = '0;
    for (k = 0; k < GROUP_W; k++) begin
      if (bits[k] == want_set) begin
        m[2*k]   = 1'b1;
        m[2*k+1] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: sv/lrps_core.sv
// Sequencer state, pulse step logic and pulse length register.
`default_nettype none

module lrps_core import lrps_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [TICK_W-1:0]  cfg_wr_data,
  input  wire logic               fire,
  input  wire logic               mode,
  input  wire logic [CMD_W-1:0]   cmd,
  output lrps_result_t            res
);

  seq_step_t            step_r, step_nxt;
  logic [CMD_W-1:0]     stored_r, stored_nxt;
  logic [GROUP_W-1:0]   grp_a_r, grp_a_nxt;
  logic [GROUP_W-1:0]   grp_b_r, grp_b_nxt;
  logic [TICK_W-1:0]    tick_r, tick_nxt;
  logic [LINE_W-1:0]    lines_r, lines_nxt;
  coil_t                coil_r, coil_nxt;
  logic [TICK_W-1:0]    pulse_len_r;
  logic                 expired;
  logic [GROUP_W-1:0]   cmd_a, cmd_b;

  // Split the command into even-bit and odd-bit groups
  assign cmd_a = {cmd[10], cmd[8], cmd[6], cmd[4], cmd[2], cmd[0]};
  assign cmd_b = {cmd[11], cmd[9], cmd[7], cmd[5], cmd[3], cmd[1]};
  assign expired = tick_r > pulse_len_r;

  // Hold the pulse length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_len_r <= PULSE_LEN_RST;
    end else if (cfg_wr_en) begin
      pulse_len_r <= cfg_wr_data;
    end
  end

  // Advance the state on each processed transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= STEP_IDLE;
      stored_r <= CMD_RESET;
      grp_a_r  <= '0;
      grp_b_r  <= '0;
      tick_r   <= '0;
      lines_r  <= IDLE_LINES;
      coil_r   <= COIL_IDLE;
    end else if (fire) begin
      step_r   <= step_nxt;
      stored_r <= stored_nxt;
      grp_a_r  <= grp_a_nxt;
      grp_b_r  <= grp_b_nxt;
      tick_r   <= tick_nxt;
      lines_r  <= lines_nxt;
      coil_r   <= coil_nxt;
    end
  end

  // Compute next step, latches and tick count
  always_comb begin
    step_nxt   = step_r;
    stored_nxt = stored_r;
    grp_a_nxt  = grp_a_r;
    grp_b_nxt  = grp_b_r;
    tick_nxt   = tick_r;
    lines_nxt  = lines_r;
    coil_nxt   = coil_r;
    if (mode) begin
      if (tick_r != TICK_MAX) begin
        tick_nxt = tick_r + 1'b1;
      end
    end else begin
      unique case (step_r)
        STEP_IDLE: begin
          if (cmd != stored_r) begin
            stored_nxt = cmd;
            grp_a_nxt  = cmd_a;
            grp_b_nxt  = cmd_b;
            step_nxt   = STEP_START;
          end
        end
        STEP_START: begin
          lines_nxt      = lines_r & ~pair_mask(grp_a_r, 1'b1);
          coil_nxt.a_set = 1'b1;
          coil_nxt.a_rst = 1'b1;
          tick_nxt       = '0;
          step_nxt       = STEP_WAIT_A_SET;
        end
        STEP_WAIT_A_SET: begin
          if (expired) begin
            lines_nxt      = IDLE_LINES & ~pair_mask(grp_b_r, 1'b1);
            coil_nxt.a_set = 1'b0;
            coil_nxt.a_rst = 1'b1;
            coil_nxt.b_set = 1'b1;
            coil_nxt.b_rst = 1'b1;
            tick_nxt       = '0;
            step_nxt       = STEP_WAIT_B_SET;
          end
        end
        STEP_WAIT_B_SET: begin
          if (expired) begin
            lines_nxt      = IDLE_LINES | pair_mask(grp_a_r, 1'b0);
            coil_nxt.b_set = 1'b0;
            coil_nxt.b_rst = 1'b1;
            coil_nxt.a_set = 1'b0;
            coil_nxt.a_rst = 1'b0;
            tick_nxt       = '0;
            step_nxt       = STEP_WAIT_A_RST;
          end
        end
        STEP_WAIT_A_RST: begin
          if (expired) begin
            lines_nxt      = IDLE_LINES | pair_mask(grp_b_r, 1'b0);
            coil_nxt.a_set = 1'b0;
            coil_nxt.a_rst = 1'b1;
            coil_nxt.b_set = 1'b0;
            coil_nxt.b_rst = 1'b0;
            tick_nxt       = '0;
            step_nxt       = STEP_WAIT_B_RST;
          end
        end
        STEP_WAIT_B_RST: begin
          if (expired) begin
            lines_nxt      = IDLE_LINES;
            coil_nxt.b_set = 1'b0;
            coil_nxt.b_rst = 1'b1;
            tick_nxt       = '0;
            step_nxt       = STEP_IDLE;
          end
        end
        default: begin
          step_nxt = STEP_IDLE;
        end
      endcase
    end
  end

  // Drive the result from the post-step state
  assign res.relay_lines = lines_nxt;
  assign res.coil        = coil_nxt;
  assign res.busy        = (step_nxt != STEP_IDLE);

  // A set coil is only ever driven together with its reset coil
  a_coil_a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    coil_r.a_set |-> coil_r.a_rst)
    else $error("group A set coil without reset coil");

  a_coil_b_pair: assert property (@(posedge clk) disable iff (!rst_n)
    coil_r.b_set |-> coil_r.b_rst)
    else $error("group B set coil without reset coil");

  // Idle step always shows the idle drive pattern
  a_idle_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == STEP_IDLE) |-> (coil_r == COIL_IDLE && lines_r == IDLE_LINES))
    else $error("idle step with non-idle drive pattern");

  // A tick never moves the sequence
  a_tick_holds_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && mode) |=> $stable(step_r))
    else $error("tick transaction changed the sequence step");

endmodule

`default_nettype wire

FILE: sv/latching_relay_pulse_sequencer.sv
// Top level: input register, sequencer core and result register.
//
//   channel  direction  handshake              payload
//   in_      in         in_valid / in_stall    in_mode, in_cmd_low, in_cmd_high
//   out_     out        out_valid / out_stall  out_relay_lines, out_group_*, out_busy_res
//   cfg_     in         cfg_wr_en              cfg_wr_data (pulse_length)
//
// One transaction per cycle is accepted unless in_stall is high; its result is offered later.
// The input register and the result register form a two-stage pipe; the core state
// updates when the held transaction moves into the result register.
// A stalled result holds the pipe; the input register still takes one transaction.
// Synchronous active-low reset restores idle lines 0x555, reset coils on, pulse length 5.
`default_nettype none

module latching_relay_pulse_sequencer import lrps_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [7:0]         cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_mode,
  input  wire logic [7:0]         in_cmd_low,
  input  wire logic [7:0]         in_cmd_high,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [11:0]             out_relay_lines,
  output logic                    out_group_a_set,
  output logic                    out_group_a_reset,
  output logic                    out_group_b_set,
  output logic                    out_group_b_reset,
  output logic                    out_busy_res
);

  logic               hold_valid_r, hold_valid_nxt;
  logic               mode_r;
  logic [CMD_W-1:0]   cmd_r;
  logic               out_valid_r, out_valid_nxt;
  lrps_result_t       res_r;
  lrps_result_t       res;
  logic               in_accept;
  logic               advance;

  // Move the held transaction on when the result register is free or draining
  assign advance   = hold_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = hold_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    hold_valid_nxt = in_accept ? 1'b1 : (hold_valid_r && !advance);
    out_valid_nxt  = advance ? 1'b1 : (out_valid_r && out_stall);
  end

  // Hold the accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode_r <= in_mode;
      cmd_r  <= {in_cmd_high, in_cmd_low};
    end
  end

  lrps_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (advance),
    .mode        (mode_r),
    .cmd         (cmd_r),
    .res         (res)
  );

  // Capture the result transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_relay_lines   = res_r.relay_lines;
  assign out_group_a_set   = res_r.coil.a_set;
  assign out_group_a_reset = res_r.coil.a_rst;
  assign out_group_b_set   = res_r.coil.b_set;
  assign out_group_b_reset = res_r.coil.b_rst;
  assign out_busy_res      = res_r.busy;

  // Every processed transaction lands in the result register
  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed transaction did not produce a result");

  // Input side stalls only while a transaction is held
  a_stall_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (hold_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked transaction");

  // A held transaction that cannot move stays held
  a_hold_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_valid_r && !advance) |=> hold_valid_r)
    else $error("held transaction dropped");

endmodule

`default_nettype wire

FILE: test/tb_latching_relay_pulse_sequencer.sv
// Self-checking testbench for the latching relay pulse sequencer.
module tb_latching_relay_pulse_sequencer;
  timeunit 1ns;
  timeprecision 1ps;
  import lrps_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;
  localparam int HOLD_CYCLES  = 120;
  localparam int CHUNKS       = 5;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_mode = 1'b0;
  logic [7:0]  in_cmd_low = '0;
  logic [7:0]  in_cmd_high = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] out_relay_lines;
  logic        out_group_a_set;
  logic        out_group_a_reset;
  logic        out_group_b_set;
  logic        out_group_b_reset;
  logic        out_busy_res;

  logic        out_hold = 1'b0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          cycles = 0;
  int          errors = 0;
  int          items_sent = 0;
  int          results_checked = 0;
  int          sequences_done = 0;
  int          length_writes = 0;
  int          input_stall_cycles = 0;

  // Relay sequencer state as the testbench tracks it
  logic [7:0]  rly_pulse_len;
  seq_step_t   rly_step;
  logic [15:0] rly_cmd;
  logic [5:0]  rly_grp_a;
  logic [5:0]  rly_grp_b;
  logic [7:0]  rly_ticks;
  logic [11:0] rly_lines;
  coil_t       rly_coils;

  lrps_result_t expected_results[$];

  latching_relay_pulse_sequencer u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_cmd_low        (in_cmd_low),
    .in_cmd_high       (in_cmd_high),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_relay_lines   (out_relay_lines),
    .out_group_a_set   (out_group_a_set),
    .out_group_a_reset (out_group_a_reset),
    .out_group_b_set   (out_group_b_set),
    .out_group_b_reset (out_group_b_reset),
    .out_busy_res      (out_busy_res)
  );

  always #10 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               expected_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Drive result back-pressure: long hold-off or random stall
  always @(posedge clk) begin
    out_stall <= out_hold || ($urandom_range(99) < stall_pct);
  end

  // Both switch lines of every relay whose group bit equals level
  function automatic logic [11:0] relay_pairs(input logic [5:0] bits, input logic level);
    logic [11:0] lines;
    int          k;
    lines = '0;
    for (k = 0; k < 6; k++) begin
      if (bits[k] == level) lines[2*k +: 2] = 2'b11;
    end
    return lines;
  endfunction

  // Start a set pulse (turn_on) or a reset pulse on one coil group
  task automatic start_group_pulse(input logic on_b, input logic turn_on);
    logic [5:0] bits;
    bits = on_b ? rly_grp_b : rly_grp_a;
    if (turn_on) begin
      rly_lines = rly_lines & ~relay_pairs(bits, 1'b1);
      if (on_b) {rly_coils.b_set, rly_coils.b_rst} = 2'b11;
      else      {rly_coils.a_set, rly_coils.a_rst} = 2'b11;
    end else begin
      rly_lines = rly_lines | relay_pairs(bits, 1'b0);
      if (on_b) {rly_coils.b_set, rly_coils.b_rst} = 2'b00;
      else      {rly_coils.a_set, rly_coils.a_rst} = 2'b00;
    end
    rly_ticks = '0;
  endtask

  // Drop the running pulse and restore idle lines and coils of the group
  task automatic stop_group_pulse(input logic on_b);
    if (on_b) {rly_coils.b_set, rly_coils.b_rst} = 2'b01;
    else      {rly_coils.a_set, rly_coils.a_rst} = 2'b01;
    rly_lines = IDLE_LINES;
    rly_ticks = '0;
  endtask

  task automatic reset_relay_state();
    rly_pulse_len = PULSE_LEN_RST;
    rly_step      = STEP_IDLE;
    rly_cmd       = CMD_RESET;
    rly_grp_a     = '0;
    rly_grp_b     = '0;
    rly_ticks     = '0;
    rly_lines     = IDLE_LINES;
    rly_coils     = COIL_IDLE;
  endtask

  // Advance the tracked state by one transaction and form the expected result
  task automatic advance_relay_state(input logic mode, input logic [15:0] cmd,
                                     output lrps_result_t res);
    logic expired;
    expired = rly_ticks > rly_pulse_len;
    if (mode) begin
      if (rly_ticks != TICK_MAX) rly_ticks = rly_ticks + 8'd1;
    end else begin
      case (rly_step)
        STEP_IDLE: begin
          if (cmd != rly_cmd) begin
            rly_cmd   = cmd;
            rly_grp_a = {cmd[10], cmd[8], cmd[6], cmd[4], cmd[2], cmd[0]};
            rly_grp_b = {cmd[11], cmd[9], cmd[7], cmd[5], cmd[3], cmd[1]};
            rly_step  = STEP_START;
          end
        end
        STEP_START: begin
          start_group_pulse(1'b0, 1'b1);
          rly_step = STEP_WAIT_A_SET;
        end
        STEP_WAIT_A_SET: begin
          if (expired) begin
            stop_group_pulse(1'b0);
            start_group_pulse(1'b1, 1'b1);
            rly_step = STEP_WAIT_B_SET;
          end
        end
        STEP_WAIT_B_SET: begin
          if (expired) begin
            stop_group_pulse(1'b1);
            start_group_pulse(1'b0, 1'b0);
            rly_step = STEP_WAIT_A_RST;
          end
        end
        STEP_WAIT_A_RST: begin
          if (expired) begin
            stop_group_pulse(1'b0);
            start_group_pulse(1'b1, 1'b0);
            rly_step = STEP_WAIT_B_RST;
          end
        end
        STEP_WAIT_B_RST: begin
          if (expired) begin
            stop_group_pulse(1'b1);
            rly_step = STEP_IDLE;
            sequences_done++;
          end
        end
        default: begin
          rly_step = STEP_IDLE;
        end
      endcase
    end
    res.relay_lines = rly_lines;
    res.coil        = rly_coils;
    res.busy        = (rly_step != STEP_IDLE);
  endtask

  // Offer one transaction, hold it until accepted, then record its result
  task automatic send_item(input logic mode, input logic [7:0] lo, input logic [7:0] hi);
    lrps_result_t res;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_cmd_low  <= lo;
    in_cmd_high <= hi;
    @(posedge clk);
    while (in_stall) begin
      input_stall_cycles++;
      @(posedge clk);
    end
    advance_relay_state(mode, {hi, lo}, res);
    expected_results.push_back(res);
    items_sent++;
  endtask

  // Mostly well-formed traffic: new commands when idle, ticks while pulsing
  task automatic send_random_item();
    logic        mode;
    logic [15:0] cmd;
    if (rly_step == STEP_IDLE) mode = ($urandom_range(99) < 15);
    else                       mode = ($urandom_range(99) < 65);
    cmd = 16'($urandom);
    if (!mode && $urandom_range(99) < 10) cmd = rly_cmd;
    send_item(mode, cmd[7:0], cmd[15:8]);
  endtask

  // Stop offering and wait until every result is back and the pipe is empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_pulse_length(input logic [7:0] len);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    rly_pulse_len = len;
    length_writes++;
  endtask

  task automatic set_idling(input int idle, input int stall);
    idle_pct = idle;
    stall_pct <= stall;
  endtask

  // Full sequence at pulse length 0, with an ignored command and an early pass
  task automatic walk_sequence(input logic [15:0] cmd);
    send_item(1'b0, cmd[7:0], cmd[15:8]);
    send_item(1'b0, cmd[7:0], cmd[15:8]);
    send_item(1'b0, ~cmd[7:0], ~cmd[15:8]);
    repeat (4) begin
      send_item(1'b1, cmd[7:0], cmd[15:8]);
      send_item(1'b0, cmd[7:0], cmd[15:8]);
    end
  endtask

  task automatic test_directed();
    set_idling(0, 0);
    // Unchanged command keeps the block idle; a tick only counts
    send_item(1'b0, CMD_RESET[7:0], CMD_RESET[15:8]);
    send_item(1'b1, 8'h00, 8'hFF);
    drain();
    write_pulse_length(8'd0);
    walk_sequence(16'hFFFF);
    walk_sequence(16'h0000);
    drain();
  endtask

  task automatic test_pulse_length_extremes();
    logic [15:0] cmd;
    set_idling(0, 0);
    // Out-of-range length: the wait never ends, ticks saturate
    write_pulse_length(8'd255);
    cmd = ~rly_cmd;
    send_item(1'b0, cmd[7:0], cmd[15:8]);
    send_item(1'b0, cmd[7:0], cmd[15:8]);
    repeat (260) send_item(1'b1, 8'($urandom), 8'($urandom));
    repeat (2) send_item(1'b0, 8'($urandom), 8'($urandom));
    drain();
    // Largest legal length: boundary of the wait compare
    write_pulse_length(8'd254);
    send_item(1'b0, 8'($urandom), 8'($urandom));
    repeat (254) send_item(1'b1, 8'($urandom), 8'($urandom));
    send_item(1'b0, 8'($urandom), 8'($urandom));
    send_item(1'b1, 8'($urandom), 8'($urandom));
    send_item(1'b0, 8'($urandom), 8'($urandom));
    drain();
    // Finish the sequence quickly and settle on the stored command
    write_pulse_length(8'd0);
    repeat (3) begin
      send_item(1'b1, rly_cmd[7:0], rly_cmd[15:8]);
      send_item(1'b0, rly_cmd[7:0], rly_cmd[15:8]);
    end
    drain();
  endtask

  task automatic test_random_traffic(input int count, input int idle, input int stall);
    int chunk;
    set_idling(idle, stall);
    for (chunk = 0; chunk < CHUNKS; chunk++) begin
      drain();
      if ($urandom_range(7) == 0) write_pulse_length(8'($urandom_range(40)));
      else                        write_pulse_length(8'($urandom_range(6)));
      repeat (count / CHUNKS) send_random_item();
    end
    drain();
  endtask

  // Hold results off for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    set_idling(0, 0);
    drain();
    write_pulse_length(8'd2);
    fork
      begin
        out_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_hold <= 1'b0;
      end
    join_none
    repeat (60) send_random_item();
    drain();
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    lrps_result_t got;
    lrps_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.relay_lines = out_relay_lines;
      got.coil.a_set  = out_group_a_set;
      got.coil.a_rst  = out_group_a_reset;
      got.coil.b_set  = out_group_b_set;
      got.coil.b_rst  = out_group_b_reset;
      got.busy        = out_busy_res;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("[%0t] unexpected result lines=%03h busy=%b", $realtime,
                   got.relay_lines, got.busy);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (got.relay_lines !== want.relay_lines || got.coil.a_set !== want.coil.a_set ||
            got.coil.a_rst !== want.coil.a_rst || got.coil.b_set !== want.coil.b_set ||
            got.coil.b_rst !== want.coil.b_rst || got.busy !== want.busy) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("[%0t] result %0d: exp lines=%03h PS1=%b PR1=%b PS2=%b PR2=%b busy=%b",
                     $realtime, results_checked,
                     want.relay_lines, want.coil.a_set, want.coil.a_rst,
                     want.coil.b_set, want.coil.b_rst, want.busy);
            $display("    act lines=%03h PS1=%b PR1=%b PS2=%b PR2=%b busy=%b",
                     got.relay_lines, got.coil.a_set, got.coil.a_rst,
                     got.coil.b_set, got.coil.b_rst, got.busy);
          end
        end
      end
    end
  end

  initial begin
    reset_relay_state();
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_pulse_length_extremes();
    test_random_traffic(400, 0, 0);
    test_random_traffic(400, 68, 0);
    test_random_traffic(400, 0, 68);
    test_random_traffic(400, 31, 31);
    test_backpressure();
    drain();

    $display("Sent %0d transactions, checked %0d results, %0d full relay sequences",
             items_sent, results_checked, sequences_done);
    $display("%0d pulse-length writes, input held off for %0d cycles, %0d errors",
             length_writes, input_stall_cycles, errors);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
